// ===== hw/rtl/hlr_pkg.sv =====
// shared constants, types and state codes for the histogram rectangle block
package hlr_pkg;

   localparam int MAX_BARS_DEF    = 1024;
   localparam int HEIGHT_BITS_DEF = 16;
   localparam int HEIGHT_PORT_BITS = 16;
   localparam int AREA_BITS        = 26;
   localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_POP,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic score;
      logic clear;
   } area_cmd_type;

endpackage

// ===== hw/rtl/histogram_largest_rectangle.sv =====
// top level: stack sequencer for the largest rectangle in a histogram
//
// usage:
//   bars enter on the req_ channel (req_height, req_last), one item per
//   handshake. req_last marks the final bar of a histogram. after that bar
//   the block drains its stack and offers one item on the rsp_ channel:
//   rsp_max_area (saturated at 26 bits) and rsp_overflowed, which is set
//   when more than MAX_BARS bars arrived and only the first ones counted.
//   non-final bars give no result item.
// sequence:
//   a kept bar is compared with the stack top; each stacked bar it pops
//   takes a stack memory read of the entry below the top and a scoring
//   step that feeds the area multiply, and then the bar is pushed. after
//   the final bar the drain pops each remaining entry the same way and
//   then loads the result register.
// reset and stall:
//   reset empties the stack and clears the counters; stack memory needs no
//   clearing pass. a result waits in its output register while rsp_ready is
//   low; the next histogram's bars are still taken, and only its own result
//   waits until the register is free.
module histogram_largest_rectangle #(
   parameter int MAX_BARS    = hlr_pkg::MAX_BARS_DEF,
   parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [hlr_pkg::HEIGHT_PORT_BITS-1:0]  req_height,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [hlr_pkg::AREA_BITS-1:0]         rsp_max_area,
   output logic                                  rsp_overflowed
);
   import hlr_pkg::*;

   localparam int HW = (HEIGHT_BITS < HEIGHT_PORT_BITS) ? HEIGHT_BITS : HEIGHT_PORT_BITS;
   localparam int PW = $clog2(MAX_BARS);
   localparam int CW = $clog2(MAX_BARS + 1);
   localparam int DW = PW + HW;

   state_type              state_ff, state_in;
   logic [HW-1:0]          h_ff, h_in;
   logic                   last_ff, last_in;
   logic                   drain_ff, drain_in;
   logic                   ovf_ff, ovf_in;
   logic [CW-1:0]          depth_ff, depth_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [HW-1:0]          top_h_ff, top_h_in;
   logic [PW-1:0]          top_pos_ff, top_pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AREA_BITS-1:0]   rsp_area_ff, rsp_area_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   wr_en;
   logic                   rd_en;
   logic [DW-1:0]          rd_data;
   logic [PW-1:0]          below_pos;
   logic [HW-1:0]          below_h;
   logic [CW-1:0]          left;
   logic [CW-1:0]          score_w;
   logic [CW-1:0]          depth_m2;
   logic                   pop_go;
   area_cmd_type           area_cmd;
   logic [AREA_BITS-1:0]   max_area;

   assign below_pos = rd_data[DW-1:HW];
   assign below_h   = rd_data[HW-1:0];
   assign depth_m2  = depth_ff - CW'(2);
   assign left      = (depth_ff >= CW'(2)) ? (CW'(below_pos) + CW'(1)) : '0;
   assign score_w   = count_ff - left;
   assign pop_go    = (depth_ff != '0) && (drain_ff || top_h_ff >= h_ff);

   hlr_stack_mem #(
      .DEPTH     (MAX_BARS),
      .DATA_BITS (DW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (depth_ff[PW-1:0]),
      .wr_data ({count_ff[PW-1:0], h_ff}),
      .rd_en   (rd_en),
      .rd_addr (depth_m2[PW-1:0]),
      .rd_data (rd_data)
   );

   hlr_area_unit #(
      .HW (HW),
      .CW (CW)
   ) u_area (
      .clock    (clock),
      .reset    (reset),
      .cmd      (area_cmd),
      .score_h  (top_h_ff),
      .score_w  (score_w),
      .max_area (max_area)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         depth_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         ovf_ff       <= ovf_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      last_ff     <= last_in;
      top_h_ff    <= top_h_in;
      top_pos_ff  <= top_pos_in;
      rsp_area_ff <= rsp_area_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      last_in      = last_ff;
      drain_in     = drain_ff;
      ovf_in       = ovf_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      top_h_in     = top_h_ff;
      top_pos_in   = top_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_area_in  = rsp_area_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      area_cmd     = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               h_in    = req_height[HW-1:0];
               last_in = req_last;
               if (count_ff >= CW'(MAX_BARS)) begin
                  ovf_in = 1'b1;
                  if (req_last) begin
                     drain_in = 1'b1;
                     state_in = ST_CMP;
                  end
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            if (pop_go) begin
               rd_en    = 1'b1;
               state_in = ST_POP;
            end else if (drain_ff) begin
               state_in = ST_LOAD;
            end else begin
               wr_en      = 1'b1;
               top_h_in   = h_ff;
               top_pos_in = count_ff[PW-1:0];
               depth_in   = depth_ff + CW'(1);
               count_in   = count_ff + CW'(1);
               if (last_ff) begin
                  drain_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_POP: begin
            area_cmd.score = 1'b1;
            depth_in       = depth_ff - CW'(1);
            if (depth_ff >= CW'(2)) begin
               top_h_in   = below_h;
               top_pos_in = below_pos;
            end
            state_in = ST_CMP;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_area_in    = max_area;
               rsp_ovf_in     = ovf_ff;
               area_cmd.clear = 1'b1;
               depth_in       = '0;
               count_in       = '0;
               ovf_in         = 1'b0;
               drain_in       = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_max_area   = rsp_area_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // stack never deeper than the bars kept
   a_depth_le_count: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= count_ff)
      else $error("stack depth exceeds bar count");

   a_count_le_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BARS))
      else $error("bar count beyond capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> (depth_ff != '0))
      else $error("pop from empty stack");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && depth_ff == '0 && count_ff == '0 && !drain_ff))
      else $error("result load did not clear state");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("stack read and write in one cycle");

endmodule

// ===== hw/rtl/hlr_stack_mem.sv =====
// stack storage: one write port and one registered read port
module hlr_stack_mem #(
   parameter int DEPTH = 1024,
   parameter int DATA_BITS = 26
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0]       wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_BITS-1:0]       rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/hlr_area_unit.sv =====
// candidate area multiply and running maximum with output saturation
module hlr_area_unit #(
   parameter int HW = 16,
   parameter int CW = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hlr_pkg::area_cmd_type         cmd,
   input  logic [HW-1:0]                 score_h,
   input  logic [CW-1:0]                 score_w,
   output logic [hlr_pkg::AREA_BITS-1:0] max_area
);
   import hlr_pkg::*;

   localparam int AW = HW + CW;
   localparam int SW = (AW > AREA_BITS) ? AW : AREA_BITS;

   logic [AW-1:0] prod_ff;
   logic [AW-1:0] prod_in;
   logic          prod_vld_ff;
   logic [AW-1:0] best_ff;
   logic [SW-1:0] best_x;

   assign prod_in = AW'(score_h) * AW'(score_w);

   always_ff @(posedge clock) begin
      if (cmd.score) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         prod_vld_ff <= 1'b0;
         best_ff     <= '0;
      end else begin
         prod_vld_ff <= cmd.score;
         if (prod_vld_ff && prod_ff > best_ff) begin
            best_ff <= prod_ff;
         end
      end
   end

   assign best_x   = SW'(best_ff);
   assign max_area = (best_x > SW'(AREA_MAX)) ? AREA_MAX : best_x[AREA_BITS-1:0];

endmodule
